// File: hw/rtl/pressure_altitude_interpolator_unit_assert.svh
// assertion macros for the pressure altitude interpolator
// expects signals named clock and reset in the module that uses them
`ifndef PRESSURE_ALTITUDE_INTERPOLATOR_UNIT_ASSERT_SVH
`define PRESSURE_ALTITUDE_INTERPOLATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PAI_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pai: implication check failed");
// next-cycle implication
`define PAI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pai: next-cycle check failed");
`else
`define PAI_ASSERT_IMPLY(label, ante, cons)
`define PAI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/pai_pkg.sv
// shared widths, register map and breakpoint/coefficient tables
// for the pressure altitude interpolator; no dependencies
package pai_pkg;

   // field and datapath widths
   localparam int PA_W     = 17;
   localparam int ALT_W    = 16;
   localparam int ROM_SEGS = 32;
   localparam int SEG_W    = 5;
   localparam int DX_W     = PA_W + 1;
   localparam int DXM_W    = 14;
   localparam int SQ_W     = 2 * DXM_W;
   localparam int A_W      = 32;
   localparam int B_W      = 24;
   localparam int C_W      = 15;
   localparam int FRAC_A   = 40;
   localparam int FRAC_B   = 20;
   localparam int HEIGHT_W = 57;
   localparam int BDX_W    = HEIGHT_W - FRAC_B;
   localparam int DIFF_W   = HEIGHT_W + 1;
   localparam int Q_W      = DIFF_W - FRAC_A;
   localparam int STAGES   = 7;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_SEA_LEVEL = 1'b0;
   localparam logic [PA_W-1:0] SEA_LEVEL_RESET = 17'd100310;

   // output limits
   localparam logic signed [ALT_W-1:0] ALT_MAX = 16'sh7FFF;
   localparam logic signed [ALT_W-1:0] ALT_MIN = 16'sh8000;

   typedef logic signed [HEIGHT_W-1:0] height_type;

   // breakpoint pressures, descending, pascals
   localparam logic [PA_W-1:0] BP_PA [0:ROM_SEGS] = '{
      17'd101325, 17'd95461, 17'd89875, 17'd84556, 17'd79495, 17'd70109,
      17'd61640,  17'd54020, 17'd47181, 17'd41061, 17'd35600, 17'd30742,
      17'd26436,  17'd22632, 17'd19330, 17'd16510, 17'd14102, 17'd12045,
      17'd10287,  17'd8787,  17'd7505,  17'd6410,  17'd5475,  17'd4678,
      17'd4000,   17'd3422,  17'd2930,  17'd2511,  17'd2153,  17'd1847,
      17'd1586,   17'd1363,  17'd1172
   };

   // breakpoint heights, whole metres
   localparam logic [C_W-1:0] BP_M [0:ROM_SEGS-1] = '{
      15'd0,     15'd500,   15'd1000,  15'd1500,  15'd2000,  15'd3000,
      15'd4000,  15'd5000,  15'd6000,  15'd7000,  15'd8000,  15'd9000,
      15'd10000, 15'd11000, 15'd12000, 15'd13000, 15'd14000, 15'd15000,
      15'd16000, 15'd17000, 15'd18000, 15'd19000, 15'd20000, 15'd21000,
      15'd22000, 15'd23000, 15'd24000, 15'd25000, 15'd26000, 15'd27000,
      15'd28000, 15'd29000
   };

   // quadratic coefficients, 2^-40 m/Pa^2
   localparam logic [A_W-1:0] QUAD_A [0:ROM_SEGS-1] = '{
      32'd386899,     32'd429101,     32'd478155,     32'd538556,
      32'd617114,     32'd813766,     32'd993870,     32'd1302042,
      32'd1631255,    32'd2141886,    32'd2736596,    32'd3650627,
      32'd4725874,    32'd7863536,    32'd10974756,   32'd14851025,
      32'd20492393,   32'd27735179,   32'd39210715,   32'd51349105,
      32'd73641352,   32'd97530243,   32'd141058788,  32'd191315364,
      32'd261001504,  32'd369210589,  32'd495707452,  32'd668791466,
      32'd923158103,  32'd1291289638, 32'd1707760500, 32'd2331043840
   };

   // linear coefficients, 2^-20 m/Pa
   localparam logic signed [B_W-1:0] LIN_B [0:ROM_SEGS-1] = '{
      -24'sd87244,   -24'sd91572,   -24'sd96143,   -24'sd100994,
      -24'sd106193,  -24'sd117241,  -24'sd130386,  -24'sd144831,
      -24'sd161815,  -24'sd180857,  -24'sd203167,  -24'sd228524,
      -24'sd258506,  -24'sd292795,  -24'sd342320,  -24'sd401351,
      -24'sd469560,  -24'sd549960,  -24'sd642959,  -24'sd755142,
      -24'sd880702,  -24'sd1034505, -24'sd1208438, -24'sd1422869,
      -24'sd1670275, -24'sd1958016, -24'sd2304489, -24'sd2700648,
      -24'sd3157319, -24'sd3696119, -24'sd4338966, -24'sd5065323
   };

endpackage

// File: hw/rtl/pai_height.sv
// five-stage pipeline that turns one pressure into a height in 2^-40 m
// depends on pai_pkg for the tables and widths
module pai_height #(
   parameter int SEGMENTS      = 32,
   parameter int PRESSURE_BITS = 17
) (
   input  logic                   clock,
   input  logic [pai_pkg::PA_W-1:0] pressure,
   output pai_pkg::height_type    height,
   output logic                   below
);
   import pai_pkg::*;

   localparam int NSEG      = (SEGMENTS < ROM_SEGS) ? SEGMENTS : ROM_SEGS;
   localparam int MASK_BITS = (PRESSURE_BITS < PA_W) ? PRESSURE_BITS : PA_W;
   localparam logic [PA_W-1:0] PMASK = PA_W'((64'd1 << MASK_BITS) - 64'd1);

   // stage 1 signals
   logic [PA_W-1:0]  p_masked;
   logic [ROM_SEGS:0] ge;
   logic [SEG_W-1:0] seg_in, s1_seg_ff;
   logic [PA_W-1:0]  s1_p_ff;
   logic             s1_lin_ff, s1_below_ff;

   // stage 2 signals
   logic [PA_W-1:0]         bp_sel;
   logic [PA_W-1:0]         bp_gap;
   logic signed [DX_W-1:0]  dx_in, s2_dx_ff;
   logic [DXM_W-1:0]        dxm_in, s2_dxm_ff;
   logic signed [B_W-1:0]   b_in, s2_b_ff;
   logic [C_W-1:0]          c_in, s2_c_ff;
   logic [A_W-1:0]          s2_a_ff;
   logic                    s2_below_ff;

   // stage 3 signals
   logic [SQ_W-1:0]         sq_in, s3_sq_ff;
   logic signed [BDX_W-1:0] bdx_in, s3_bdx_ff;
   logic [A_W-1:0]          s3_a_ff;
   logic [C_W-1:0]          s3_c_ff;
   logic                    s3_below_ff;

   // stage 4 signals
   logic [A_W+SQ_W-1:0]     quad_prod;
   height_type              quad_in, s4_quad_ff;
   height_type              base_in, s4_base_ff;
   logic                    s4_below_ff;

   // stage 5 signals
   height_type              height_in, s5_height_ff;
   logic                    s5_below_ff;

   // segment search: breakpoints are descending, so ge is a thermometer code
   always_comb begin
      p_masked = pressure & PMASK;
      for (int i = 0; i <= ROM_SEGS; i++) begin
         ge[i] = (BP_PA[i] >= p_masked);
      end
      seg_in = '0;
      for (int i = 0; i < ROM_SEGS; i++) begin
         if (ge[i] && !ge[i+1]) begin
            seg_in = SEG_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_p_ff     <= p_masked;
      s1_seg_ff   <= seg_in;
      s1_lin_ff   <= !ge[0];
      s1_below_ff <= ge[NSEG];
   end

   // coefficient fetch and offset from the upper breakpoint
   always_comb begin
      bp_sel = BP_PA[{1'b0, s1_seg_ff}];
      bp_gap = bp_sel - s1_p_ff;
      dx_in  = $signed({1'b0, s1_p_ff}) - $signed({1'b0, bp_sel});
      // quadratic term only inside the table
      dxm_in = (s1_lin_ff || s1_below_ff) ? '0 : bp_gap[DXM_W-1:0];
      b_in   = s1_below_ff ? '0 : LIN_B[s1_seg_ff];
      c_in   = s1_below_ff ? '0 : BP_M[s1_seg_ff];
   end

   always_ff @(posedge clock) begin
      s2_dx_ff    <= dx_in;
      s2_dxm_ff   <= dxm_in;
      s2_a_ff     <= QUAD_A[s1_seg_ff];
      s2_b_ff     <= b_in;
      s2_c_ff     <= c_in;
      s2_below_ff <= s1_below_ff;
   end

   // square of the offset and the linear product
   assign sq_in  = SQ_W'(s2_dxm_ff) * SQ_W'(s2_dxm_ff);
   assign bdx_in = s2_b_ff * s2_dx_ff;

   always_ff @(posedge clock) begin
      s3_sq_ff    <= sq_in;
      s3_bdx_ff   <= bdx_in;
      s3_a_ff     <= s2_a_ff;
      s3_c_ff     <= s2_c_ff;
      s3_below_ff <= s2_below_ff;
   end

   // quadratic product and the aligned linear plus constant part
   always_comb begin
      quad_prod = s3_a_ff * s3_sq_ff;
      quad_in   = $signed({1'b0, quad_prod[HEIGHT_W-2:0]});
      base_in   = $signed({s3_bdx_ff, {FRAC_B{1'b0}}})
                + $signed({{(HEIGHT_W-C_W-FRAC_A){1'b0}}, s3_c_ff, {FRAC_A{1'b0}}});
   end

   always_ff @(posedge clock) begin
      s4_quad_ff  <= quad_in;
      s4_base_ff  <= base_in;
      s4_below_ff <= s3_below_ff;
   end

   // final height
   assign height_in = s4_quad_ff + s4_base_ff;

   always_ff @(posedge clock) begin
      s5_height_ff <= height_in;
      s5_below_ff  <= s4_below_ff;
   end

   assign height = s5_height_ff;
   assign below  = s5_below_ff;

endmodule

// File: hw/rtl/pressure_altitude_interpolator_unit.sv
// top level of the pressure altitude interpolator: csr, valid pipeline, difference and output
// depends on pai_pkg, pai_height and pressure_altitude_interpolator_unit_assert.svh
//
// One pressure sample is taken on every clock where start is high; busy never rises, so a
// transaction may follow in the very next cycle. Each sample yields one result on
// rsp_altitude_m / rsp_below_table / rsp_saturated, shown for exactly one cycle with
// rsp_valid high, after the sample has passed five stages in the height datapath, one for the
// difference and one for truncation and clipping. The receiver cannot stall the
// block. The reference height for sea_level_pa is computed every cycle by a second copy of
// the height datapath, so sea_level_pa must only be written when no transaction is in flight.
`include "pressure_altitude_interpolator_unit_assert.svh"

module pressure_altitude_interpolator_unit #(
   parameter int SEGMENTS      = 32,
   parameter int PRESSURE_BITS = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample channel
   input  logic                          start,
   output logic                          busy,
   input  logic [pai_pkg::PA_W-1:0]      req_pressure_pa,
   // result channel
   output logic                          rsp_valid,
   output logic signed [pai_pkg::ALT_W-1:0] rsp_altitude_m,
   output logic                          rsp_below_table,
   output logic                          rsp_saturated,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pai_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pai_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pai_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import pai_pkg::*;

   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(ALT_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(ALT_MIN);

   logic                    accept;
   logic [STAGES-1:0]       vld_ff, vld_in;
   logic [PA_W-1:0]         sea_level_ff;
   logic                    csr_write;

   height_type              sample_height, ref_height;
   logic                    sample_below, ref_below;

   logic signed [DIFF_W-1:0] diff_in, diff_ff;
   logic                     below6_ff;

   logic signed [Q_W-1:0]   q_floor, q_trunc;
   logic                    frac_nz;
   logic signed [ALT_W-1:0] alt_in, alt_ff;
   logic                    sat_in, sat_ff;
   logic                    below_ff;

   // the pipeline takes a transaction every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_IDX_SEA_LEVEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         sea_level_ff <= SEA_LEVEL_RESET;
      end else if (csr_write) begin
         sea_level_ff <= pwdata[PA_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_SEA_LEVEL)
                 ? {{(CSR_DATA_W-PA_W){1'b0}}, sea_level_ff} : '0;

   // valid bits travel alongside the datapath
   assign vld_in = {vld_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // sample and reference height datapaths
   pai_height #(
      .SEGMENTS      (SEGMENTS),
      .PRESSURE_BITS (PRESSURE_BITS)
   ) u_sample (
      .clock    (clock),
      .pressure (req_pressure_pa),
      .height   (sample_height),
      .below    (sample_below)
   );

   pai_height #(
      .SEGMENTS      (SEGMENTS),
      .PRESSURE_BITS (PRESSURE_BITS)
   ) u_reference (
      .clock    (clock),
      .pressure (sea_level_ff),
      .height   (ref_height),
      .below    (ref_below)
   );

   // height difference
   assign diff_in = DIFF_W'(sample_height) - DIFF_W'(ref_height);

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      below6_ff <= sample_below;
   end

   // truncate toward zero to whole metres, then clip to 16 bits
   always_comb begin
      q_floor = diff_ff[DIFF_W-1:FRAC_A];
      frac_nz = |diff_ff[FRAC_A-1:0];
      q_trunc = q_floor + Q_W'(diff_ff[DIFF_W-1] && frac_nz);
      if (q_trunc > Q_MAX) begin
         alt_in = ALT_MAX;
         sat_in = 1'b1;
      end else if (q_trunc < Q_MIN) begin
         alt_in = ALT_MIN;
         sat_in = 1'b1;
      end else begin
         alt_in = q_trunc[ALT_W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      alt_ff   <= alt_in;
      sat_ff   <= sat_in;
      below_ff <= below6_ff;
   end

   assign rsp_valid       = vld_ff[STAGES-1];
   assign rsp_altitude_m  = alt_ff;
   assign rsp_below_table = below_ff;
   assign rsp_saturated   = sat_ff;

   // every accepted transaction comes out after the fixed latency
   `PAI_ASSERT_IMPLY(a_latency, start && !busy, ##STAGES rsp_valid)
   // a clipped result sits at one of the range limits
   `PAI_ASSERT_IMPLY(a_sat_limit, rsp_valid && rsp_saturated, alt_ff == ALT_MAX || alt_ff == ALT_MIN)
   // a write to the reference register lands on the next cycle
   `PAI_ASSERT_NEXT(a_csr_write, csr_write, sea_level_ff == $past(pwdata[PA_W-1:0]))
   // a reference below the table contributes no height
   `PAI_ASSERT_IMPLY(a_ref_below, vld_ff[STAGES-3] && ref_below, ref_height == '0)

endmodule

// File: test/pressure_altitude_interpolator_unit_tb.sv
// self-checking testbench for pressure_altitude_interpolator_unit: random and edge-case
// pressure samples under several sea-level settings; needs pai_pkg and the unit itself
`timescale 1ns / 100ps

module pressure_altitude_interpolator_unit_tb;
   import pai_pkg::*;

   localparam int SEGMENTS        = 32;
   localparam int PRESSURE_BITS   = 17;
   localparam int PHASES          = 8;
   localparam int SAMPLES_PER_PHASE = 140;
   localparam int RANDOM_PHASE    = 6;
   localparam int MAX_PRINTED     = 20;
   localparam logic [CSR_ADDR_W-1:0] SEA_LEVEL_ADDR = CSR_ADDR_W'(4 * CSR_IDX_SEA_LEVEL);
   localparam logic [PA_W-1:0] PA_TOP = {PA_W{1'b1}};

   // edge-case samples: table ends, breakpoints and their neighbors, bit patterns
   localparam logic [PA_W-1:0] EDGE_SAMPLES [0:23] = '{
      17'd0,      17'd1,      17'd1171,   17'd1172,   17'd1173,   17'd1362,
      17'd1363,   17'd1364,   17'd2511,   17'd4000,   17'd19330,  17'd26436,
      17'd43690,  17'd50000,  17'd65536,  17'd70110,  17'd79495,  17'd79496,
      17'd87381,  17'd100310, 17'd101324, 17'd101325, 17'd101326, 17'd131071
   };

   // sea-level settings per phase; the random phase draws its own
   localparam logic [PA_W-1:0] SEA_LEVEL_PLAN [0:PHASES-1] = '{
      SEA_LEVEL_RESET, 17'd0, 17'd131071, 17'd1172,
      17'd101325, 17'd1173, 17'd0, SEA_LEVEL_RESET
   };

   // sender idle percentage per phase, cycled
   localparam int IDLE_PLAN [0:2] = '{0, 50, 7};

   typedef struct {
      logic [PA_W-1:0]         pressure;
      logic signed [ALT_W-1:0] altitude;
      logic                    below;
      logic                    clipped;
   } altitude_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [PA_W-1:0]         req_pressure_pa = '0;
   logic                    rsp_valid;
   logic signed [ALT_W-1:0] rsp_altitude_m;
   logic                    rsp_below_table;
   logic                    rsp_saturated;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr = '0;
   logic [CSR_DATA_W-1:0]   pwdata = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   logic [PA_W-1:0]     pending_samples [$];
   altitude_result_type expected_altitudes [$];
   altitude_result_type oldest;
   logic [PA_W-1:0]  sea_level_shadow = SEA_LEVEL_RESET;
   logic [PA_W-1:0]  setting;
   int               idle_pct = 0;
   int               mismatches = 0;
   int               results_seen = 0;
   int               below_seen = 0;
   int               above_seen = 0;

   pressure_altitude_interpolator_unit #(
      .SEGMENTS(SEGMENTS),
      .PRESSURE_BITS(PRESSURE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pressure_pa(req_pressure_pa),
      .rsp_valid(rsp_valid),
      .rsp_altitude_m(rsp_altitude_m),
      .rsp_below_table(rsp_below_table),
      .rsp_saturated(rsp_saturated),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // height in units of 2^-40 m for one pressure; flags a pressure at or below the table
   function automatic longint height_fx(input logic [PA_W-1:0] p, output bit below);
      longint ps, dx, upper, lower, coef_a, coef_b, base_m;
      int nseg;
      nseg = (SEGMENTS < ROM_SEGS) ? SEGMENTS : ROM_SEGS;
      ps = p;
      ps = ps & ((longint'(1) << PRESSURE_BITS) - 1);
      below = 1'b0;
      for (int i = 0; i < nseg; i++) begin
         upper = BP_PA[i];
         lower = BP_PA[i+1];
         if (upper >= ps && ps > lower) begin
            dx = ps - upper;
            coef_a = QUAD_A[i];
            coef_b = LIN_B[i];
            base_m = BP_M[i];
            return coef_a * dx * dx + coef_b * dx * (longint'(1) << FRAC_B)
                 + base_m * (longint'(1) << FRAC_A);
         end
      end
      upper = BP_PA[0];
      // above the table: linear extrapolation of the first segment
      if (ps >= upper) begin
         dx = ps - upper;
         coef_b = LIN_B[0];
         base_m = BP_M[0];
         return coef_b * dx * (longint'(1) << FRAC_B) + base_m * (longint'(1) << FRAC_A);
      end
      below = 1'b1;
      return 0;
   endfunction

   // altitude of a sample relative to the current sea-level setting
   function automatic altitude_result_type predict_altitude(input logic [PA_W-1:0] p);
      altitude_result_type r;
      longint hs, hr, metres;
      bit below_s, below_r;
      hs = height_fx(p, below_s);
      hr = height_fx(sea_level_shadow, below_r);
      metres = (hs - hr) / (longint'(1) << FRAC_A);
      r.pressure = p;
      r.below = below_s;
      r.clipped = 1'b0;
      if (metres > ALT_MAX) begin
         metres = ALT_MAX;
         r.clipped = 1'b1;
      end else if (metres < ALT_MIN) begin
         metres = ALT_MIN;
         r.clipped = 1'b1;
      end
      r.altitude = metres[ALT_W-1:0];
      return r;
   endfunction

   // random sample, weighted toward breakpoints and both table ends
   function automatic logic [PA_W-1:0] pick_pressure();
      int sel, v;
      sel = $urandom_range(9);
      case (sel)
         0, 1: v = $urandom_range(PA_TOP);
         2, 3: v = int'(BP_PA[$urandom_range(ROM_SEGS)]) + int'($urandom_range(6)) - 3;
         4: v = $urandom_range(BP_PA[ROM_SEGS]);
         5: v = $urandom_range(PA_TOP, BP_PA[0] + 1);
         default: v = $urandom_range(BP_PA[0], BP_PA[ROM_SEGS] + 1);
      endcase
      return v[PA_W-1:0];
   endfunction

   // sample driver: accepts on start && !busy, then offers the next pending sample
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_pressure_pa <= '0;
      end else begin
         if (start && !busy) begin
            expected_altitudes.push_back(predict_altitude(req_pressure_pa));
            if (req_pressure_pa <= BP_PA[ROM_SEGS]) below_seen++;
            if (req_pressure_pa > BP_PA[0]) above_seen++;
         end
         if (start && busy) begin
            // hold the current transaction
         end else if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_pressure_pa <= pending_samples.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor: one strobe per transaction, compared in order
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_altitudes.size() == 0) begin
            report_mismatch($sformatf("result with none pending, altitude %0d",
                                      rsp_altitude_m));
         end else begin
            oldest = expected_altitudes.pop_front();
            if (rsp_altitude_m !== oldest.altitude)
               report_mismatch($sformatf("p=%0d ref=%0d altitude %0d, want %0d",
                  oldest.pressure, sea_level_shadow, rsp_altitude_m, oldest.altitude));
            if (rsp_below_table !== oldest.below)
               report_mismatch($sformatf("p=%0d below_table %b, want %b",
                  oldest.pressure, rsp_below_table, oldest.below));
            if (rsp_saturated !== oldest.clipped)
               report_mismatch($sformatf("p=%0d saturated %b, want %b",
                  oldest.pressure, rsp_saturated, oldest.clipped));
         end
      end
   end

   task automatic write_sea_level(input logic [PA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SEA_LEVEL_ADDR;
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sea_level_shadow = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic read_sea_level();
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= SEA_LEVEL_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(sea_level_shadow))
         report_mismatch($sformatf("sea_level_pa reads %0d, want %0d", prdata,
                                   sea_level_shadow));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // wait until every queued sample has been taken and answered, then let the pipe settle
   task automatic wait_until_drained();
      @(negedge clock);
      while (pending_samples.size() != 0 || start || expected_altitudes.size() != 0)
         @(negedge clock);
      repeat (STAGES + 3) @(posedge clock);
   endtask

   // stimulus plan
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      read_sea_level();

      // edge cases at the reset sea-level setting
      @(negedge clock);
      idle_pct = 0;
      foreach (EDGE_SAMPLES[i]) pending_samples.push_back(EDGE_SAMPLES[i]);
      wait_until_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            setting = (ph == RANDOM_PHASE) ? PA_W'($urandom_range(PA_TOP))
                                           : SEA_LEVEL_PLAN[ph];
            write_sea_level(setting);
            read_sea_level();
         end
         @(negedge clock);
         idle_pct = IDLE_PLAN[ph % 3];
         repeat (SAMPLES_PER_PHASE) pending_samples.push_back(pick_pressure());
         wait_until_drained();
      end

      if (expected_altitudes.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_altitudes.size()));
      $display("checked %0d altitude results over %0d sea-level settings", results_seen,
               PHASES);
      $display("%0d samples below the table, %0d above it, %0d mismatches", below_seen,
               above_seen, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("timeout waiting for results");
      $display("Some tests failed");
      $finish;
   end

endmodule
